// File: rtl/ord_pkg.sv
// package: item types, mode codes and default sizes for the overwriting ring deque
`timescale 1ns / 1ps

package ord_pkg;

    localparam int CAPACITY_DEF  = 15;
    localparam int WORD_BITS_DEF = 32;

    localparam int MODE_W  = 3;
    localparam int IN_WORD_W = 32;
    localparam int OUT_WORD_W = 32;
    localparam int OCC_W   = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 3'd0,
        MODE_READ_OLD = 3'd1,
        MODE_PEEK_OLD = 3'd2,
        MODE_READ_NEW = 3'd3,
        MODE_PEEK_NEW = 3'd4,
        MODE_SEARCH   = 3'd5,
        MODE_CLEAR    = 3'd6
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [IN_WORD_W-1:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [OUT_WORD_W-1:0] result_word;
        logic                  hit;
        logic [OCC_W-1:0]      occupancy;
    } t_out_item;

endpackage

// File: rtl/ord_ram.sv
// slot memory: one write port, one read port, registered read data
`timescale 1ns / 1ps

module ord_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/overwriting_ring_deque_top.sv
// top level: ring deque controller with pointers, count and the slot memory
`timescale 1ns / 1ps

// channel   | ports                        | handshake
// ----------+------------------------------+--------------------------------
// command   | start, busy, i_item          | item taken when start && !busy
// result    | o_strobe, o_item             | one-cycle strobe per item, no stall
//
// an add that does not evict, clear, unused codes and any read, peek or
//   search on an empty ring finish without a slot read (result on the next cycle)
// an evicting add, a read or a peek issues one slot memory read, returned through ST_FETCH
// a search scans the ring: it reads one live slot per cycle
//   from oldest to newest through the single read port and stops on a match
// reset clears pointers and count; slot contents are not cleared
// results are never held back, busy alone paces the command side

module overwriting_ring_deque_top
    import ord_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_item
);

    localparam int NSLOTS = CAPACITY + 1;
    localparam int PTR_W  = $clog2(NSLOTS);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY);
    localparam logic [PTR_W-1:0] CAP_CNT  = PTR_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [PTR_W-1:0]     r_count, n_count;   // count fits the pointer width
    logic [PTR_W-1:0]     r_scan;
    logic [WORD_BITS-1:0] r_word;

    logic                 accept;
    t_mode                mode;
    logic                 empty;
    logic                 full;
    logic                 need_read;
    logic [WORD_BITS-1:0] word_in;
    logic                 match;
    logic                 scan_end;

    logic                 mem_we;
    logic                 mem_re;
    logic [PTR_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [IN_WORD_W+WORD_BITS-1:0]  word_ext;
    logic [WORD_BITS+OUT_WORD_W-1:0] rd_ext;
    logic [PTR_W+OCC_W-1:0]          occ_now_ext;
    logic [PTR_W+OCC_W-1:0]          occ_next_ext;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign mode   = t_mode'(i_item.mode);
    assign empty  = (r_count == '0);
    assign full   = (r_count == CAP_CNT);

    // incoming word kept to the slot width
    assign word_ext = {{WORD_BITS{1'b0}}, i_item.data_word};
    assign word_in  = word_ext[WORD_BITS-1:0];

    // read slot fitted to the result field
    assign rd_ext = {{OUT_WORD_W{1'b0}}, mem_rdata};

    // occupancy field is the count masked to its width
    assign occ_now_ext  = {{OCC_W{1'b0}}, r_count};
    assign occ_next_ext = {{OCC_W{1'b0}}, n_count};

    // scan compare: data is the slot read in the previous cycle
    assign match    = (mem_rdata == r_word);
    assign scan_end = (r_scan == r_head);

    // pointer and count update, decided at accept time
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_state   = ST_IDLE;
        need_read = 1'b0;
        mem_raddr = r_tail;
        unique case (mode)
            MODE_ADD: begin
                n_head = ptr_next(r_head);
                if (full) begin
                    n_tail    = ptr_next(r_tail);
                    need_read = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_READ_OLD: begin
                if (!empty) begin
                    n_tail    = ptr_next(r_tail);
                    n_count   = r_count - 1'b1;
                    need_read = 1'b1;
                end
            end
            MODE_PEEK_OLD: begin
                need_read = !empty;
            end
            MODE_READ_NEW: begin
                mem_raddr = ptr_prev(r_head);
                if (!empty) begin
                    n_head    = ptr_prev(r_head);
                    n_count   = r_count - 1'b1;
                    need_read = 1'b1;
                end
            end
            MODE_PEEK_NEW: begin
                mem_raddr = ptr_prev(r_head);
                need_read = !empty;
            end
            MODE_SEARCH: begin
                need_read = !empty;
            end
            MODE_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (need_read) begin
            n_state = (mode == MODE_SEARCH) ? ST_SCAN : ST_FETCH;
        end
        // during a scan the read port walks the live slots
        if (r_state == ST_SCAN) begin
            mem_raddr = r_scan;
        end
    end

    // add writes its word at head; an evicting add reads tail, never the same slot
    assign mem_we = accept && (mode == MODE_ADD);
    assign mem_re = (accept && need_read) ||
                    ((r_state == ST_SCAN) && !match && !scan_end);

    ord_ram #(
        .DEPTH  (NSLOTS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_head),
        .i_wdata (word_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer, pointers and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_head  <= n_head;
                        r_tail  <= n_tail;
                        r_count <= n_count;
                        r_state <= n_state;
                        r_word  <= word_in;
                        r_scan  <= ptr_next(r_tail);
                        if (!need_read) begin
                            // nothing to fetch: result goes out right away
                            o_strobe              <= 1'b1;
                            o_item.result_word    <= '0;
                            o_item.hit            <= 1'b0;
                            o_item.occupancy      <= occ_next_ext[OCC_W-1:0];
                        end
                    end
                end
                ST_FETCH: begin
                    o_strobe           <= 1'b1;
                    o_item.result_word <= rd_ext[OUT_WORD_W-1:0];
                    o_item.hit         <= 1'b1;
                    o_item.occupancy   <= occ_now_ext[OCC_W-1:0];
                    r_state            <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (match || scan_end) begin
                        o_strobe           <= 1'b1;
                        o_item.result_word <= '0;
                        o_item.hit         <= match;
                        o_item.occupancy   <= occ_now_ext[OCC_W-1:0];
                        r_state            <= ST_IDLE;
                    end else begin
                        r_scan <= ptr_next(r_scan);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // count stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("item count beyond capacity");

    // pointers agree with the count on emptiness
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == r_tail))
        else $error("pointers disagree with item count");

    // a result is only issued when the sequencer has returned to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == ST_IDLE))
        else $error("result issued while still busy");

    // write and read never hit the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && (mem_raddr == r_head)))
        else $error("read and write to the same slot");

    // a fetch returns its hit result in the next cycle and goes back to idle
    a_fetch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (o_strobe && o_item.hit && (r_state == ST_IDLE)))
        else $error("fetch did not complete in one cycle");

endmodule
